### rtl/core/bm3s_pkg.sv
// Shared constants for the 3D morphology block.
package bm3s_pkg;

    localparam int MAX_RADIUS = 3;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_DEPTH  = 256;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_RADIUS = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DEPTH  = 3'd4;

    localparam int DIM_W = 9;
    localparam int CFG_W = 9;

endpackage

### rtl/core/binary_morphology_3d_sphere.sv
// Top level: 3D binary dilation/erosion with a spherical element over a volume store.
// Whole volume is written into the store; a released result sweeps the (2r+1)^3 cube
// through the single read port, one neighbour a cycle, and input is ready again in the
// cycle after the result is taken. Sync active-low reset: mode 0, radius 1, 256^3;
// input is held off after reset or a register write while a settle counter runs down.
module binary_morphology_3d_sphere #(
    parameter int MAX_RADIUS = bm3s_pkg::MAX_RADIUS,
    parameter int MAX_WIDTH  = bm3s_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = bm3s_pkg::MAX_HEIGHT,
    parameter int MAX_DEPTH  = bm3s_pkg::MAX_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [bm3s_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // voxel
    input  logic                       s_axis_tuser,  // flush
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // result_voxel, out_x, out_y, out_z
    output logic                       m_axis_tlast
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int ZW = $clog2(MAX_DEPTH);
    localparam int AW = XW + YW + ZW;
    localparam int DW = bm3s_pkg::DIM_W;
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int SW = DW + 2;
    localparam int GW = 3 * DW + 1;

    localparam logic [2:0] ST_IN   = 3'd0;
    localparam logic [2:0] ST_SWP  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic          r_mode;
    logic [1:0]    r_radius;
    logic [DW-1:0] r_w, r_h, r_p;
    logic [DW-1:0] w, h, p;
    logic [RW-1:0] rr;

    logic [DW-1:0] r_ix, r_iy, r_iz;
    logic [DW-1:0] r_ox, r_oy, r_oz;
    logic [2:0]    r_st;
    logic [RW:0]   r_dx, r_dy, r_dz;
    logic          r_chk, r_vin, r_acc;
    logic          r_ovalid, r_ores, r_olast;
    logic [7:0]    r_tx, r_ty, r_tz;
    logic [GW-1:0] r_span, r_lag, r_gap;
    logic [1:0]    r_settle;

    function automatic logic [DW-1:0] clampd(input logic [DW-1:0] v, input int mx);
        if (v == '0) return DW'(1);
        if (32'(v) > mx) return DW'(mx);
        return v;
    endfunction

    assign w = clampd(r_w, MAX_WIDTH);
    assign h = clampd(r_h, MAX_HEIGHT);
    assign p = clampd(r_p, MAX_DEPTH);
    assign rr = (32'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);

    logic in_done, is_flush, wr;
    logic [DW-1:0] n_ix, n_iy, n_iz;
    assign in_done  = (r_iz >= p);
    assign s_axis_tready = (r_st == ST_IN) && (r_settle == 2'd0);
    assign is_flush = s_axis_tuser;

    // Input advance
    always_comb begin
        n_ix = r_ix; n_iy = r_iy; n_iz = r_iz;
        if (r_ix + 1'b1 >= w) begin
            n_ix = '0;
            if (r_iy + 1'b1 >= h) begin
                n_iy = '0;
                n_iz = r_iz + 1'b1;
            end else begin
                n_iy = r_iy + 1'b1;
            end
        end else begin
            n_ix = r_ix + 1'b1;
        end
    end
    assign wr = s_axis_tvalid && s_axis_tready && !in_done && !is_flush;

    // window lag r*(W*H + W + 1), two register stages
    always_ff @(posedge i_clk) begin
        r_span <= GW'(w) * GW'(h) + GW'(w) + GW'(1);
        r_lag  <= GW'(rr) * r_span;
    end

    // Release test: words held beyond the next result exceed the lag, or volume complete.
    logic [GW-1:0] gap_nx;
    logic n_done, rel;
    always_comb begin
        gap_nx = r_gap + GW'(wr);
        n_done = wr ? (n_iz >= p) : in_done;
        rel = n_done || (gap_nx > r_lag);
    end

    // Neighbour address and validity
    logic signed [SW-1:0] nx, ny, nz;
    logic nin, nsph;
    logic [AW-1:0] raddr, waddr;
    logic rdata;
    always_comb begin
        logic signed [SW-1:0] ddx, ddy, ddz;
        ddx = SW'(signed'(r_dx));
        ddy = SW'(signed'(r_dy));
        ddz = SW'(signed'(r_dz));
        nx = SW'(r_ox) + ddx;
        ny = SW'(r_oy) + ddy;
        nz = SW'(r_oz) + ddz;
        nin = nx >= 0 && ny >= 0 && nz >= 0 && nx < SW'(w) && ny < SW'(h) && nz < SW'(p);
        nsph = (ddx*ddx + ddy*ddy + ddz*ddz) <= SW'(rr)*SW'(rr);
    end
    assign raddr = {ZW'(nz), YW'(ny), XW'(nx)};
    assign waddr = {ZW'(r_iz), YW'(r_iy), XW'(r_ix)};

    bm3s_store #(.ADDR_W(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(waddr),
        .i_wdata(s_axis_tdata[0]),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [RW:0] rneg;
    assign rneg = -(RW+1)'(rr);
    logic sweep_end;
    assign sweep_end = (r_dx == (RW+1)'(rr)) && (r_dy == (RW+1)'(rr)) &&
                       (r_dz == (RW+1)'(rr));
    logic olast;
    assign olast = (r_ox + 1'b1 == w) && (r_oy + 1'b1 == h) && (r_oz + 1'b1 == p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_radius <= 2'd1;
            r_w <= DW'(256); r_h <= DW'(256); r_p <= DW'(256);
            r_ix <= '0; r_iy <= '0; r_iz <= '0;
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_st <= ST_IN; r_chk <= 1'b0; r_ovalid <= 1'b0;
            r_gap <= '0; r_settle <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bm3s_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                bm3s_pkg::REG_RADIUS: r_radius <= i_cfg_data[1:0];
                bm3s_pkg::REG_WIDTH:  r_w      <= i_cfg_data;
                bm3s_pkg::REG_HEIGHT: r_h      <= i_cfg_data;
                bm3s_pkg::REG_DEPTH:  r_p      <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index <= bm3s_pkg::REG_DEPTH) begin
                r_ix <= '0; r_iy <= '0; r_iz <= '0;
                r_ox <= '0; r_oy <= '0; r_oz <= '0;
                r_st <= ST_IN; r_chk <= 1'b0; r_ovalid <= 1'b0;
                r_gap <= '0; r_settle <= 2'd2;
            end
        end else begin
            r_chk <= (r_st == ST_SWP) && nsph;
            if (r_settle != 2'd0) r_settle <= r_settle - 1'b1;
            unique case (r_st)
                ST_IN: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (wr) begin
                            r_ix <= n_ix; r_iy <= n_iy; r_iz <= n_iz;
                        end
                        r_gap <= gap_nx;
                        if (rel) begin
                            r_st <= ST_SWP;
                            r_dx <= rneg; r_dy <= rneg; r_dz <= rneg;
                            r_acc <= r_mode;
                        end
                    end
                end
                ST_SWP: begin
                    r_vin <= nin;
                    if (sweep_end) r_st <= ST_WAIT;
                    else if (r_dx == (RW+1)'(rr)) begin
                        r_dx <= rneg;
                        if (r_dy == (RW+1)'(rr)) begin
                            r_dy <= rneg; r_dz <= r_dz + 1'b1;
                        end else r_dy <= r_dy + 1'b1;
                    end else r_dx <= r_dx + 1'b1;
                end
                ST_WAIT: if (!r_chk) begin
                    r_ovalid <= 1'b1;
                    r_ores <= r_acc;
                    r_olast <= olast;
                    r_tx <= 8'(r_ox); r_ty <= 8'(r_oy); r_tz <= 8'(r_oz);
                    r_st <= ST_OUT;
                end
                ST_OUT: if (m_axis_tready) begin
                    r_ovalid <= 1'b0;
                    r_st <= ST_IN;
                    if (r_olast) begin
                        r_ix <= '0; r_iy <= '0; r_iz <= '0;
                        r_ox <= '0; r_oy <= '0; r_oz <= '0;
                        r_gap <= '0;
                    end else begin
                        r_gap <= r_gap - 1'b1;
                        if (r_ox + 1'b1 >= w) begin
                            r_ox <= '0;
                            if (r_oy + 1'b1 >= h) begin
                                r_oy <= '0; r_oz <= r_oz + 1'b1;
                            end else r_oy <= r_oy + 1'b1;
                        end else r_ox <= r_ox + 1'b1;
                    end
                end
                default: r_st <= ST_IN;
            endcase
            // fold in read data in the cycle after its address
            if (r_chk) begin
                if (r_mode) begin
                    if (!(r_vin && rdata)) r_acc <= 1'b0;
                end else if (r_vin && rdata) r_acc <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_tz, r_ty, r_tx, r_ores};
    assign m_axis_tlast  = r_olast;

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_st == ST_OUT) else $error("result valid outside output state");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !i_cfg_we |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

### rtl/core/bm3s_store.sv
// Volume store: one-bit memory, one write and one registered read a cycle.
module bm3s_store #(
    parameter int ADDR_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [2**ADDR_W];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
